/* rtl/core/wft_pkg.sv */
// Shared types and constants for the Winograd F(4x4,3x3) filter transform.
// No dependencies; used by every module under rtl/core.
package wft_pkg;

  // Tile geometry
  localparam int TAP_N   = 3;
  localparam int TILE_N  = 6;
  localparam int POS_W   = $clog2(TILE_N);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TILE_N - 1);

  // Field widths
  localparam int W_W     = 16;   // filter tap, Q3.12
  localparam int T_W     = 21;   // after the column pass
  localparam int S_W     = 26;   // after the row pass (exact integer sum)
  localparam int VAL_W   = 24;   // result value, Q3.20
  localparam int IDX_W   = 24;   // destination index
  localparam int CH_W    = 9;    // channel index
  localparam int CFG_W   = 10;   // channel count register
  localparam int STR_W   = 2 * CFG_W;

  localparam int MAX_CHANNELS = 512;

  // floor(x / 18) = (x * RECIP) >> RECIP_SH for x below 2^X_W
  localparam int X_W      = 29;
  localparam int P_W      = 2 * X_W;
  localparam int RECIP_SH = 33;
  localparam int Q_W      = P_W - RECIP_SH;
  localparam logic [X_W-1:0] RECIP    = X_W'(477218589);
  localparam logic [X_W-1:0] ROUND_K  = X_W'(9);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [T_W-1:0] tval_t;
  typedef logic signed [S_W-1:0] sval_t;
  typedef sval_t srow_t [TILE_N];

  // Register map
  typedef enum logic [0:0] {
    CFG_OUT_CHANNELS = 1'b0,
    CFG_IN_CHANNELS  = 1'b1
  } cfg_idx_t;

  // Side information that travels with each result
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

endpackage

/* rtl/core/wft_lane.sv */
// One transform lane: multiplies a 3-vector by 24*G (6x3), giving 6 values.
// Depends on wft_pkg.
module wft_lane (
  input  wft_pkg::tval_t a,
  input  wft_pkg::tval_t b,
  input  wft_pkg::tval_t c,
  output wft_pkg::srow_t o
);

  wft_pkg::sval_t ax, bx, cx;
  wft_pkg::sval_t sum_p, sum_m;

  assign ax = wft_pkg::sval_t'(a);
  assign bx = wft_pkg::sval_t'(b);
  assign cx = wft_pkg::sval_t'(c);

  assign sum_p = ax + bx + cx;
  assign sum_m = ax - bx + cx;

  // Rows of 24*G, shifts and adds only
  always_comb begin
    o[0] = (ax <<< 2) + (ax <<< 1);
    o[1] = -(sum_p <<< 2);
    o[2] = -(sum_m <<< 2);
    o[3] = ax + (bx <<< 1) + (cx <<< 2);
    o[4] = ax - (bx <<< 1) + (cx <<< 2);
    o[5] = (cx <<< 4) + (cx <<< 3);
  end

endmodule

/* rtl/core/wft_merge.sv */
// Merge stage: picks one lane result, scales by 4/9 with rounding, saturates.
// Four register stages; depends on wft_pkg.
module wft_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_v,
  input  wft_pkg::srow_t               row,
  input  logic [wft_pkg::POS_W-1:0]    sel,
  input  wft_pkg::tag_t                in_tag,
  output logic                         out_valid,
  output logic signed [wft_pkg::VAL_W-1:0] out_tile_value,
  output logic [wft_pkg::IDX_W-1:0]    out_dest_index,
  output logic                         out_last
);

  logic v1_r, v2_r, v3_r, v4_r;
  wft_pkg::sval_t            s1_r;
  logic                      neg2_r, neg3_r;
  logic [wft_pkg::X_W-1:0]   x2_r;
  logic [wft_pkg::P_W-1:0]   prod3_r;
  logic [wft_pkg::VAL_W-1:0] val4_r;
  wft_pkg::tag_t             tag1_r, tag2_r, tag3_r, tag4_r;

  logic [wft_pkg::S_W-1:0]   mag;
  logic [wft_pkg::X_W-1:0]   x_nxt;
  logic [wft_pkg::Q_W-1:0]   q;
  logic [wft_pkg::Q_W-1:0]   q_neg;
  logic [wft_pkg::VAL_W-1:0] val_nxt;

  // |s| * 8 + 9, so that floor(./18) rounds s*4/9 to nearest
  assign mag   = s1_r[wft_pkg::S_W-1] ? wft_pkg::S_W'(-s1_r) : wft_pkg::S_W'(s1_r);
  assign x_nxt = {mag, 3'b000} + wft_pkg::ROUND_K;

  // Quotient from the reciprocal product, then sign and clamp
  assign q     = prod3_r[wft_pkg::P_W-1:wft_pkg::RECIP_SH];
  assign q_neg = ~q + wft_pkg::Q_W'(1);

  always_comb begin
    if (!neg3_r) begin
      if (q > wft_pkg::Q_W'(wft_pkg::VAL_MAX)) val_nxt = wft_pkg::VAL_MAX;
      else                                      val_nxt = q[wft_pkg::VAL_W-1:0];
    end else begin
      if (q > wft_pkg::Q_W'(wft_pkg::VAL_MIN)) val_nxt = wft_pkg::VAL_MIN;
      else                                      val_nxt = q_neg[wft_pkg::VAL_W-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= row[sel];
      tag1_r  <= in_tag;
      neg2_r  <= s1_r[wft_pkg::S_W-1];
      x2_r    <= x_nxt;
      tag2_r  <= tag1_r;
      neg3_r  <= neg2_r;
      prod3_r <= wft_pkg::P_W'(x2_r) * wft_pkg::P_W'(wft_pkg::RECIP);
      tag3_r  <= tag2_r;
      val4_r  <= val_nxt;
      tag4_r  <= tag3_r;
    end
  end

  assign out_valid      = v4_r;
  assign out_tile_value = val4_r;
  assign out_dest_index = tag4_r.idx;
  assign out_last       = tag4_r.last;

`ifndef SYNTHESIS
  // A non-negative sum never yields a negative value
  a_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && adv && !neg3_r |=> !out_tile_value[wft_pkg::VAL_W-1])
    else $error("positive sum gave negative value");

  // A negative sum never yields a positive value
  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && adv && neg3_r |=> out_tile_value[wft_pkg::VAL_W-1] || out_tile_value == '0)
    else $error("negative sum gave positive value");

  // A held beat keeps its valid and payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v4_r) && $stable(val4_r) && $stable(tag4_r))
    else $error("result beat changed while stalled");
`endif

endmodule

/* rtl/core/winograd_filter_transform_f4x4_3x3.sv */
// Top level of the Winograd F(4x4,3x3) filter transform.
// Holds config registers, the column lanes, tile buffer and result sequencer.
// Depends on wft_pkg, wft_lane and wft_merge.
//
//  channel | signals                               | moves per beat
//  --------+---------------------------------------+-------------------------------
//  in      | in_valid/in_ready, in_w_*, in_*channel | one 3x3 filter tile + k, c
//  out     | out_valid/out_ready, out_*             | one tile element + index, last
//  cfg     | cfg_we, cfg_index, cfg_wdata           | one channel count, no wait
//
// Each tile gives 36 results; the merge stage hands out one result per cycle unless out stalls.
// A tile's first result is registered in the tile buffer and then in each merge stage; the
// next tile is taken in the cycle the current tile issues its last element.
// Reset sets both channel counts to 512 and empties the pipeline.
// A stalled out beat freezes issue from the sequencer and all merge stages together.
module winograd_filter_transform_f4x4_3x3 (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [wft_pkg::CFG_W-1:0]             cfg_wdata,
  // filter tiles in
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r0_c0,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r0_c1,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r0_c2,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r1_c0,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r1_c1,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r1_c2,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r2_c0,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r2_c1,
  input  logic signed [wft_pkg::W_W-1:0]        in_w_r2_c2,
  input  logic [wft_pkg::CH_W-1:0]              in_out_channel,
  input  logic [wft_pkg::CH_W-1:0]              in_in_channel,
  // transformed elements out
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wft_pkg::VAL_W-1:0]      out_tile_value,
  output logic [wft_pkg::IDX_W-1:0]             out_dest_index,
  output logic                                  out_last
);

  // Channel count registers
  logic [wft_pkg::CFG_W-1:0] out_channels_r, in_channels_r;
  logic [wft_pkg::CFG_W-1:0] cfg_sat;

  assign cfg_sat = (cfg_wdata > wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS)) ?
                   wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_channels_r <= wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS);
      in_channels_r  <= wft_pkg::CFG_W'(wft_pkg::MAX_CHANNELS);
    end else if (cfg_we) begin
      case (cfg_index)
        wft_pkg::CFG_OUT_CHANNELS: out_channels_r <= cfg_sat;
        wft_pkg::CFG_IN_CHANNELS:  in_channels_r  <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Column pass: three lanes, one per filter column
  wft_pkg::tval_t g [wft_pkg::TAP_N][wft_pkg::TAP_N];
  wft_pkg::srow_t col_o [wft_pkg::TAP_N];
  wft_pkg::tval_t t_nxt [wft_pkg::TILE_N][wft_pkg::TAP_N];

  assign g[0][0] = wft_pkg::tval_t'(in_w_r0_c0);
  assign g[0][1] = wft_pkg::tval_t'(in_w_r0_c1);
  assign g[0][2] = wft_pkg::tval_t'(in_w_r0_c2);
  assign g[1][0] = wft_pkg::tval_t'(in_w_r1_c0);
  assign g[1][1] = wft_pkg::tval_t'(in_w_r1_c1);
  assign g[1][2] = wft_pkg::tval_t'(in_w_r1_c2);
  assign g[2][0] = wft_pkg::tval_t'(in_w_r2_c0);
  assign g[2][1] = wft_pkg::tval_t'(in_w_r2_c1);
  assign g[2][2] = wft_pkg::tval_t'(in_w_r2_c2);

  for (genvar cj = 0; cj < wft_pkg::TAP_N; cj++) begin : g_col
    wft_lane u_col (
      .a (g[0][cj]),
      .b (g[1][cj]),
      .c (g[2][cj]),
      .o (col_o[cj])
    );
    for (genvar ri = 0; ri < wft_pkg::TILE_N; ri++) begin : g_row
      // column pass results stay within 21 bits for 16-bit taps
      assign t_nxt[ri][cj] = col_o[cj][ri][wft_pkg::T_W-1:0];
    end
  end

  // Tile buffer and sequencer state
  wft_pkg::tval_t t_r [wft_pkg::TILE_N][wft_pkg::TAP_N];
  logic                        busy_r, busy_nxt;
  logic [wft_pkg::POS_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [wft_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [wft_pkg::STR_W-1:0]   stride_r, stride_nxt;

  logic adv, issue, last_pos, accept;
  logic [wft_pkg::STR_W-1:0]   base;

  assign adv      = !out_valid || out_ready;
  assign issue    = busy_r && adv;
  assign last_pos = (i_r == wft_pkg::POS_LAST) && (j_r == wft_pkg::POS_LAST);
  assign in_ready = !busy_r || (adv && last_pos);
  assign accept   = in_valid && in_ready;

  // c*K + k and C*K for the index walk
  assign base = wft_pkg::STR_W'(in_in_channel) * wft_pkg::STR_W'(out_channels_r) +
                wft_pkg::STR_W'(in_out_channel);

  always_comb begin
    busy_nxt   = busy_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    idx_nxt    = idx_r;
    stride_nxt = stride_r;
    if (accept) begin
      busy_nxt   = 1'b1;
      i_nxt      = '0;
      j_nxt      = '0;
      idx_nxt    = wft_pkg::IDX_W'(base);
      stride_nxt = wft_pkg::STR_W'(in_channels_r) * wft_pkg::STR_W'(out_channels_r);
    end else if (issue) begin
      if (last_pos) begin
        busy_nxt = 1'b0;
      end else if (j_r == wft_pkg::POS_LAST) begin
        j_nxt   = '0;
        i_nxt   = i_r + wft_pkg::POS_W'(1);
        idx_nxt = idx_r + wft_pkg::IDX_W'(stride_r);
      end else begin
        j_nxt   = j_r + wft_pkg::POS_W'(1);
        idx_nxt = idx_r + wft_pkg::IDX_W'(stride_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    stride_r <= stride_nxt;
    if (accept) begin
      t_r <= t_nxt;
    end
  end

  // Row pass on the current tile row
  wft_pkg::srow_t row_o;
  wft_pkg::tag_t  tag;

  wft_lane u_row (
    .a (t_r[i_r][0]),
    .b (t_r[i_r][1]),
    .c (t_r[i_r][2]),
    .o (row_o)
  );

  assign tag = {idx_r, last_pos};

  wft_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_v           (issue),
    .row            (row_o),
    .sel            (j_r),
    .in_tag         (tag),
    .out_valid      (out_valid),
    .out_tile_value (out_tile_value),
    .out_dest_index (out_dest_index),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // A tile is only taken over a busy buffer as its last element issues
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && busy_r |-> issue && last_pos)
    else $error("tile accepted over a busy buffer");

  // The buffer stays busy until its last element has issued
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !(issue && last_pos) |=> busy_r)
    else $error("tile dropped before last element");

  // Row and column counters stay inside the 6x6 tile
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (i_r <= wft_pkg::POS_LAST) && (j_r <= wft_pkg::POS_LAST))
    else $error("tile position out of range");
`endif

endmodule
